@@ sv/ssdr_pkg.sv @@
// Shared types and constants for the scalar SDR encoder.
// Holds register indexes, reset values, the config struct and the control states.
// No dependencies.
package ssdr_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_ACTIVE_CELLS = 32;
   localparam int DEF_CELL_INDEX_BITS  = 16;

   // fixed field widths
   localparam int SAMPLE_BITS = 32;
   localparam int STEP_BITS   = 31;
   localparam int CELLS_BITS  = 6;
   localparam int RANGE_BITS  = 13;
   localparam int IDX_BITS    = 16;
   localparam int CSR_IDX_BITS = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_VALUE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_VALUE    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_SIZE    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_CELLS = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_RANGE = 3'd4;

   // register reset values
   localparam logic signed [SAMPLE_BITS-1:0] RST_MIN_VALUE    = 32'sd0;
   localparam logic signed [SAMPLE_BITS-1:0] RST_MAX_VALUE    = 32'sd65536;
   localparam logic [STEP_BITS-1:0]          RST_STEP_SIZE    = 31'd256;
   localparam logic [CELLS_BITS-1:0]         RST_ACTIVE_CELLS = 6'd4;
   localparam logic [RANGE_BITS-1:0]         RST_ACTIVE_RANGE = 13'd16;

   // effective configuration, special cases already resolved
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] lo;
      logic signed [SAMPLE_BITS-1:0] hi;
      logic [STEP_BITS-1:0]          step;
      logic [RANGE_BITS-1:0]         range;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QDIV,
      ST_RNG,
      ST_RDIV,
      ST_CELL,
      ST_CDIV,
      ST_MBS,
      ST_MDIV,
      ST_BASE,
      ST_EMIT
   } state_type;

endpackage

@@ sv/ssdr_divider.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the encoder top level.
module ssdr_divider #(
   parameter int DVD_BITS = 32,
   parameter int DVS_BITS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                busy,
   output logic [DVD_BITS-1:0] quotient,
   output logic [DVS_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(DVD_BITS + 1);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [DVD_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVS_BITS-1:0] dvs_ff, dvs_in;

   logic [DVS_BITS:0] trial;
   logic [DVS_BITS:0] trial_sub;
   logic              fits;

   // one trial subtraction per cycle
   always_comb begin
      trial     = {rem_ff, quo_ff[DVD_BITS-1]};
      fits      = (trial >= {1'b0, dvs_ff});
      trial_sub = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(DVD_BITS);
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DVD_BITS-2:0], fits};
         rem_in   = fits ? trial_sub[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/ssdr_csr.sv @@
// Configuration registers of the encoder and their effective values.
// Depends on ssdr_pkg.
module ssdr_csr
   import ssdr_pkg::*;
#(
   parameter int MAX_ACTIVE_CELLS = DEF_MAX_ACTIVE_CELLS,
   localparam int CNT_W = $clog2(MAX_ACTIVE_CELLS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0]             csr_data,
   output cfg_type                 cfg,
   output logic [CNT_W-1:0]        cells_eff
);

   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [CELLS_BITS-1:0]         cells_ff, cells_in;
   logic [RANGE_BITS-1:0]         range_ff, range_in;

   assign csr_ready = 1'b1;

   // register write decode; indexes beyond the list are dropped
   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      step_in  = step_ff;
      cells_in = cells_ff;
      range_in = range_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_VALUE:    min_in   = csr_data;
            CSR_MAX_VALUE:    max_in   = csr_data;
            CSR_STEP_SIZE:    step_in  = csr_data[STEP_BITS-1:0];
            CSR_ACTIVE_CELLS: cells_in = csr_data[CELLS_BITS-1:0];
            CSR_ACTIVE_RANGE: range_in = csr_data[RANGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= RST_MIN_VALUE;
         max_ff   <= RST_MAX_VALUE;
         step_ff  <= RST_STEP_SIZE;
         cells_ff <= RST_ACTIVE_CELLS;
         range_ff <= RST_ACTIVE_RANGE;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         step_ff  <= step_in;
         cells_ff <= cells_in;
         range_ff <= range_in;
      end
   end

   // effective values: inverted bounds, zero step, zero range, cell count limits
   always_comb begin
      cfg.lo    = min_ff;
      cfg.hi    = (max_ff < min_ff) ? min_ff : max_ff;
      cfg.step  = (step_ff == '0) ? STEP_BITS'(1) : step_ff;
      cfg.range = (range_ff == '0) ? RANGE_BITS'(1) : range_ff;
      if (cells_ff == '0) begin
         cells_eff = CNT_W'(1);
      end else if (int'(cells_ff) > MAX_ACTIVE_CELLS) begin
         cells_eff = CNT_W'(MAX_ACTIVE_CELLS);
      end else begin
         cells_eff = CNT_W'(cells_ff);
      end
   end

endmodule

@@ sv/scalar_sdr_encoder.sv @@
// Scalar SDR encoder: one signed Q16.16 sample in, one transaction out per active cell.
// A sample passes through a bit-serial quantizing division, then three passes of a
// second serial divider (index by range, remainder by cell count, spread by minor bin
// size), with a setup state before each pass and one before the output, and one output
// transaction per cycle while the result side does not stall. The minor bin size is
// computed by a third small divider alongside the first division. A new sample is taken
// once the last cell of the previous one has entered the output register.
// Depends on ssdr_pkg, ssdr_csr and ssdr_divider.
module scalar_sdr_encoder
   import ssdr_pkg::*;
#(
   parameter int MAX_ACTIVE_CELLS = DEF_MAX_ACTIVE_CELLS,
   parameter int CELL_INDEX_BITS  = DEF_CELL_INDEX_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [31:0]                   csr_data,
   // sample input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   // cell output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CELL_INDEX_BITS-1:0]    rsp_cell_index,
   output logic [IDX_BITS-1:0]           rsp_step_index,
   output logic signed [SAMPLE_BITS-1:0] rsp_quantized_value,
   output logic                          rsp_clamped,
   output logic                          rsp_last_cell
);

   localparam int CNT_W   = $clog2(MAX_ACTIVE_CELLS + 1);
   localparam int KMB_W   = RANGE_BITS + CNT_W;
   localparam int SUM_W   = 32;
   localparam int PROD_W  = IDX_BITS + 1 + RANGE_BITS;
   localparam int QPROD_W = IDX_BITS + STEP_BITS;
   localparam logic [SUM_W-1:0] CELL_MAX = SUM_W'((64'd1 << CELL_INDEX_BITS) - 64'd1);

   cfg_type          cfg;
   logic [CNT_W-1:0] cells_eff;

   ssdr_csr #(.MAX_ACTIVE_CELLS(MAX_ACTIVE_CELLS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .cells_eff (cells_eff)
   );

   state_type state_ff, state_in;

   logic req_take;
   logic rsp_load;
   logic start_q, start_b;

   // quantizer divider
   logic [SAMPLE_BITS-1:0] q_quo;
   logic [STEP_BITS-1:0]   q_rem;
   logic                   q_busy;
   // minor bin size divider
   logic [RANGE_BITS-1:0]  m_quo;
   logic [CNT_W-1:0]       m_rem;
   logic                   m_busy;
   // shared small divider
   logic [IDX_BITS-1:0]    b_dvd, b_quo;
   logic [RANGE_BITS-1:0]  b_dvs, b_rem;
   logic                   b_busy;

   // sample clamp
   logic signed [SAMPLE_BITS-1:0] s_clamp;
   logic                          s_out;
   logic [SAMPLE_BITS:0]          s_diff;

   always_comb begin
      s_out   = 1'b0;
      s_clamp = req_sample_value;
      if (req_sample_value < cfg.lo) begin
         s_clamp = cfg.lo;
         s_out   = 1'b1;
      end else if (req_sample_value > cfg.hi) begin
         s_clamp = cfg.hi;
         s_out   = 1'b1;
      end
      s_diff = {s_clamp[SAMPLE_BITS-1], s_clamp} - {cfg.lo[SAMPLE_BITS-1], cfg.lo};
   end

   ssdr_divider #(.DVD_BITS(SAMPLE_BITS), .DVS_BITS(STEP_BITS)) u_qdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (start_q),
      .dividend  (s_diff[SAMPLE_BITS-1:0]),
      .divisor   (cfg.step),
      .busy      (q_busy),
      .quotient  (q_quo),
      .remainder (q_rem)
   );

   ssdr_divider #(.DVD_BITS(RANGE_BITS), .DVS_BITS(CNT_W)) u_mdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (start_q),
      .dividend  (cfg.range),
      .divisor   (cells_eff),
      .busy      (m_busy),
      .quotient  (m_quo),
      .remainder (m_rem)
   );

   ssdr_divider #(.DVD_BITS(IDX_BITS), .DVS_BITS(RANGE_BITS)) u_bdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (start_b),
      .dividend  (b_dvd),
      .divisor   (b_dvs),
      .busy      (b_busy),
      .quotient  (b_quo),
      .remainder (b_rem)
   );

   // per-sample registers
   logic                   clamped_ff, at_hi_ff;
   logic [IDX_BITS-1:0]    idx_ff;
   logic [SAMPLE_BITS-1:0] quant_ff;
   logic [RANGE_BITS-1:0]  mbs_ff;
   logic [IDX_BITS-1:0]    major_ff;
   logic [RANGE_BITS-1:0]  rem_ff, a_ff, d_ff, m_ff, inc1_ff;
   logic [CNT_W-1:0]       b_ff, k_ff;
   logic [KMB_W-1:0]       kmbs_ff;
   logic [PROD_W-1:0]      prod_ff;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CELL_INDEX_BITS-1:0]    cell_ff;
   logic [IDX_BITS-1:0]           step_out_ff;
   logic signed [SAMPLE_BITS-1:0] quant_out_ff;
   logic                          clamped_out_ff, last_ff;

   logic                   busy_any;
   logic                   last_k;
   logic [SAMPLE_BITS-1:0] idx_adj;
   logic [QPROD_W-1:0]     qprod;
   logic [RANGE_BITS-1:0]  m_plus1;
   logic [RANGE_BITS-1:0]  sel_lo;
   logic [SUM_W-1:0]       cell_sum;

   assign busy_any = q_busy | m_busy;
   assign last_k   = ((k_ff + CNT_W'(1)) == cells_eff);
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_QDIV;
         ST_QDIV: if (!busy_any) state_in = ST_RNG;
         ST_RNG:  state_in = ST_RDIV;
         ST_RDIV: if (!b_busy) state_in = ST_CELL;
         ST_CELL: state_in = ST_CDIV;
         ST_CDIV: if (!b_busy) state_in = ST_MBS;
         ST_MBS:  state_in = ST_MDIV;
         ST_MDIV: if (!b_busy) state_in = ST_BASE;
         ST_BASE: state_in = ST_EMIT;
         ST_EMIT: if (rsp_load && last_k) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      start_q   = 1'b0;
      start_b   = 1'b0;
      b_dvd     = idx_ff;
      b_dvs     = cfg.range;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            start_q   = req_valid;
         end
         ST_RNG: begin
            start_b = 1'b1;
         end
         ST_CELL: begin
            start_b = 1'b1;
            b_dvd   = IDX_BITS'(rem_ff);
            b_dvs   = RANGE_BITS'(cells_eff);
         end
         ST_MBS: begin
            start_b = 1'b1;
            b_dvd   = IDX_BITS'(a_ff);
            b_dvs   = mbs_ff;
         end
         default: ;
      endcase
   end

   assign req_take = (state_ff == ST_IDLE) && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // step index adjust and quantized value
   always_comb begin
      idx_adj = (at_hi_ff && (q_quo != '0)) ? (q_quo - SAMPLE_BITS'(1)) : q_quo;
      qprod   = QPROD_W'(idx_ff) * QPROD_W'(cfg.step);
      m_plus1 = m_ff + RANGE_BITS'(1);
   end

   // cell index: base of the major and minor bin plus offset of cell k
   always_comb begin
      sel_lo   = (k_ff < b_ff) ? inc1_ff : m_ff;
      cell_sum = SUM_W'(prod_ff) + SUM_W'(sel_lo) + SUM_W'(kmbs_ff);
   end

   // datapath registers per state
   always_ff @(posedge clock) begin
      if (req_take) begin
         clamped_ff <= s_out;
         at_hi_ff   <= (s_clamp == cfg.hi);
      end
      if ((state_ff == ST_QDIV) && !busy_any) begin
         idx_ff <= (|idx_adj[SAMPLE_BITS-1:IDX_BITS]) ? '1 : idx_adj[IDX_BITS-1:0];
         mbs_ff <= (m_quo == '0) ? RANGE_BITS'(1) : m_quo;
      end
      if (state_ff == ST_RNG) begin
         quant_ff <= (|qprod[QPROD_W-1:SAMPLE_BITS-1]) ? 32'h7FFF_FFFF
                                                        : qprod[SAMPLE_BITS-1:0];
      end
      if ((state_ff == ST_RDIV) && !b_busy) begin
         major_ff <= b_quo;
         rem_ff   <= b_rem;
      end
      if ((state_ff == ST_CDIV) && !b_busy) begin
         a_ff <= b_quo[RANGE_BITS-1:0];
         b_ff <= b_rem[CNT_W-1:0];
      end
      if ((state_ff == ST_MDIV) && !b_busy) begin
         d_ff <= b_quo[RANGE_BITS-1:0];
         m_ff <= b_rem;
      end
      if (state_ff == ST_BASE) begin
         prod_ff <= PROD_W'((PROD_W'(major_ff) + PROD_W'(d_ff)) * PROD_W'(cfg.range));
         inc1_ff <= (m_plus1 == mbs_ff) ? cfg.range : m_plus1;
         k_ff    <= '0;
         kmbs_ff <= '0;
      end
      if (rsp_load) begin
         k_ff    <= k_ff + CNT_W'(1);
         kmbs_ff <= kmbs_ff + KMB_W'(mbs_ff);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         cell_ff        <= (cell_sum > CELL_MAX) ? '1 : cell_sum[CELL_INDEX_BITS-1:0];
         step_out_ff    <= idx_ff;
         quant_out_ff   <= quant_ff;
         clamped_out_ff <= clamped_ff;
         last_ff        <= last_k;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_index      = cell_ff;
   assign rsp_step_index      = step_out_ff;
   assign rsp_quantized_value = quant_out_ff;
   assign rsp_clamped         = clamped_out_ff;
   assign rsp_last_cell       = last_ff;

endmodule
